/* src/ascsd_pkg.sv */
// ----------------------------------------------------------------------------
// ascsd_pkg
// Types, code set numbers and lookup functions shared by the broadcast text
// decoder modules.
// ----------------------------------------------------------------------------
package ascsd_pkg;

  // Code set numbers as they appear on the result channel.
  localparam logic [3:0] CS_UNKNOWN = 4'd0;
  localparam logic [3:0] CS_KANJI   = 4'd1;
  localparam logic [3:0] CS_ALNUM   = 4'd2;
  localparam logic [3:0] CS_HIRA    = 4'd3;
  localparam logic [3:0] CS_KATA    = 4'd4;
  localparam logic [3:0] CS_MOSA    = 4'd5;
  localparam logic [3:0] CS_MOSB    = 4'd6;
  localparam logic [3:0] CS_MOSC    = 4'd7;
  localparam logic [3:0] CS_MOSD    = 4'd8;
  localparam logic [3:0] CS_PALNUM  = 4'd9;
  localparam logic [3:0] CS_PHIRA   = 4'd10;
  localparam logic [3:0] CS_PKATA   = 4'd11;
  localparam logic [3:0] CS_X0201K  = 4'd12;
  localparam logic [3:0] CS_JIS1    = 4'd13;
  localparam logic [3:0] CS_JIS2    = 4'd14;
  localparam logic [3:0] CS_SYMBOLS = 4'd15;

  // Glyph status codes.
  localparam logic [1:0] GS_MAPPED = 2'd0;
  localparam logic [1:0] GS_DOLLAR = 2'd1;
  localparam logic [1:0] GS_SQUARE = 2'd2;

  // Control and escape bytes.
  localparam logic [7:0] B_ESC     = 8'h1b;
  localparam logic [7:0] B_LS0     = 8'h0f;
  localparam logic [7:0] B_LS1     = 8'h0e;
  localparam logic [7:0] B_WIDE    = 8'h24;
  localparam logic [7:0] B_LS2     = 8'h6e;
  localparam logic [7:0] B_LS3     = 8'h6f;
  localparam logic [7:0] B_LS1R    = 8'h7e;
  localparam logic [7:0] B_LS2R    = 8'h7d;
  localparam logic [7:0] B_LS3R    = 8'h7c;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_string;
  } in_t;

  typedef struct packed {
    logic [3:0] code_set;
    logic [6:0] first_code;
    logic [6:0] second_code;
    logic       two_byte;
    logic [1:0] glyph_status;
  } res_t;

  function automatic logic [3:0] set_of_final(input logic [7:0] f);
    logic [3:0] cs;
    case (f)
      8'h42:   cs = CS_KANJI;
      8'h4a:   cs = CS_ALNUM;
      8'h30:   cs = CS_HIRA;
      8'h31:   cs = CS_KATA;
      8'h32:   cs = CS_MOSA;
      8'h33:   cs = CS_MOSB;
      8'h34:   cs = CS_MOSC;
      8'h35:   cs = CS_MOSD;
      8'h36:   cs = CS_PALNUM;
      8'h37:   cs = CS_PHIRA;
      8'h38:   cs = CS_PKATA;
      8'h49:   cs = CS_X0201K;
      8'h39:   cs = CS_JIS1;
      8'h3a:   cs = CS_JIS2;
      8'h3b:   cs = CS_SYMBOLS;
      default: cs = CS_UNKNOWN;
    endcase
    return cs;
  endfunction

  function automatic logic is_wide(input logic [3:0] cs);
    return (cs == CS_KANJI) || (cs == CS_JIS1) || (cs == CS_JIS2) ||
           (cs == CS_SYMBOLS);
  endfunction

endpackage

/* src/ascsd_in_if.sv */
// ----------------------------------------------------------------------------
// ascsd_in_if
// Byte channel into the decoder: valid/ready handshake and one encoded byte.
// ----------------------------------------------------------------------------
interface ascsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_string;

  modport source (output valid, output in_byte, output start_of_string, input ready);
  modport sink   (input valid, input in_byte, input start_of_string, output ready);
endinterface

/* src/ascsd_out_if.sv */
// ----------------------------------------------------------------------------
// ascsd_out_if
// Character channel out of the decoder: valid/ready handshake and one
// decoded character.
// ----------------------------------------------------------------------------
interface ascsd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] code_set;
  logic [6:0] first_code;
  logic [6:0] second_code;
  logic       two_byte;
  logic [1:0] glyph_status;

  modport source (output valid, output code_set, output first_code, output second_code,
                  output two_byte, output glyph_status, input ready);
  modport sink   (input valid, input code_set, input first_code, input second_code,
                  input two_byte, input glyph_status, output ready);
endinterface

/* src/ascsd_in_stage.sv */
// ----------------------------------------------------------------------------
// ascsd_in_stage
// Input register: holds one accepted byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module ascsd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  ascsd_pkg::in_t    data_i,
  output logic              valid_o,
  input  logic              pop_i,
  output ascsd_pkg::in_t    data_o
);

  logic           valid_q, valid_d;
  ascsd_pkg::in_t data_q;
  logic           accept;

  // The register refills in the same cycle it is drained.
  assign ready_o = !valid_q || pop_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* src/ascsd_core.sv */
// ----------------------------------------------------------------------------
// ascsd_core
// Decode stage: designation slots, invocation pointers and escape parser.
// Each byte updates the state and yields at most one character.
// ----------------------------------------------------------------------------
module ascsd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  ascsd_pkg::in_t    item_i,
  input  logic              take_ready_i,
  output logic              pop_o,
  output logic              res_valid_o,
  output ascsd_pkg::res_t   res_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ESC,
    PH_DES1,
    PH_DES2,
    PH_DES2F,
    PH_GL2,
    PH_GR2
  } phase_e;

  logic [3:0] slots_q [4];
  logic [3:0] slots_d [4];
  logic [1:0] gl_q, gl_d;
  logic [1:0] gr_q, gr_d;
  phase_e     ph_q, ph_d;
  logic [1:0] pslot_q, pslot_d;
  logic [7:0] pfirst_q, pfirst_d;
  logic       halt_q, halt_d;

  // State as seen by this byte, after an optional start-of-string reset.
  logic [3:0] eff_slots [4];
  logic [1:0] eff_gl, eff_gr;
  phase_e     eff_ph;
  logic       eff_halt;

  logic [7:0] b;
  logic [6:0] c;
  logic [3:0] cs_gl, cs_gr, fin_cs;
  logic       emit;
  ascsd_pkg::res_t res;

  assign pop_o = item_valid_i && take_ready_i;
  assign b     = item_i.in_byte;
  assign c     = b[6:0];

  always_comb begin
    if (item_i.start_of_string) begin
      eff_slots[0] = ascsd_pkg::CS_KANJI;
      eff_slots[1] = ascsd_pkg::CS_ALNUM;
      eff_slots[2] = ascsd_pkg::CS_HIRA;
      eff_slots[3] = ascsd_pkg::CS_KATA;
      eff_gl       = 2'd0;
      eff_gr       = 2'd2;
      eff_ph       = PH_IDLE;
      pslot_d      = 2'd0;
      pfirst_d     = 8'd0;
      eff_halt     = 1'b0;
    end else begin
      eff_slots = slots_q;
      eff_gl    = gl_q;
      eff_gr    = gr_q;
      eff_ph    = ph_q;
      pslot_d   = pslot_q;
      pfirst_d  = pfirst_q;
      eff_halt  = halt_q;
    end

    cs_gl  = eff_slots[eff_gl];
    cs_gr  = eff_slots[eff_gr];
    fin_cs = ascsd_pkg::set_of_final(b);

    slots_d = eff_slots;
    gl_d    = eff_gl;
    gr_d    = eff_gr;
    halt_d  = eff_halt;
    ph_d    = PH_IDLE;
    emit    = 1'b0;
    res     = '0;

    if (eff_halt) begin
      // A broken right-half pair freezes everything until the next string.
      ph_d = eff_ph;
    end else begin
      case (eff_ph)
        PH_IDLE: begin
          if (b == ascsd_pkg::B_ESC) begin
            ph_d = PH_ESC;
          end else if (b == ascsd_pkg::B_LS0) begin
            gl_d = 2'd0;
          end else if (b == ascsd_pkg::B_LS1) begin
            gl_d = 2'd1;
          end else if (b inside {[8'h20:8'h7f]}) begin
            if (ascsd_pkg::is_wide(cs_gl)) begin
              pfirst_d = b;
              ph_d     = PH_GL2;
            end else begin
              emit             = 1'b1;
              res.code_set     = cs_gl;
              res.first_code   = c;
              res.glyph_status = ((c inside {[7'h21:7'h7e]}) &&
                                  (cs_gl inside {ascsd_pkg::CS_HIRA, ascsd_pkg::CS_KATA,
                                                 ascsd_pkg::CS_ALNUM}))
                                 ? ascsd_pkg::GS_MAPPED : ascsd_pkg::GS_DOLLAR;
            end
          end else if (b inside {[8'ha0:8'hff]}) begin
            if (ascsd_pkg::is_wide(cs_gr)) begin
              pfirst_d = b;
              ph_d     = PH_GR2;
            end else begin
              emit             = 1'b1;
              res.code_set     = cs_gr;
              res.first_code   = c;
              res.glyph_status = ((c inside {[7'h21:7'h7e]}) &&
                                  (cs_gr inside {ascsd_pkg::CS_HIRA, ascsd_pkg::CS_KATA,
                                                 ascsd_pkg::CS_ALNUM}))
                                 ? ascsd_pkg::GS_MAPPED : ascsd_pkg::GS_DOLLAR;
            end
          end
        end
        PH_ESC: begin
          if (b inside {[8'h28:8'h2b]}) begin
            pslot_d = b[1:0];
            ph_d    = PH_DES1;
          end else if (b == ascsd_pkg::B_WIDE) begin
            ph_d = PH_DES2;
          end else if (b == ascsd_pkg::B_LS2) begin
            gl_d = 2'd2;
          end else if (b == ascsd_pkg::B_LS3) begin
            gl_d = 2'd3;
          end else if (b == ascsd_pkg::B_LS1R) begin
            gr_d = 2'd1;
          end else if (b == ascsd_pkg::B_LS2R) begin
            gr_d = 2'd2;
          end else if (b == ascsd_pkg::B_LS3R) begin
            gr_d = 2'd3;
          end
        end
        PH_DES1: begin
          if (!ascsd_pkg::is_wide(fin_cs)) begin
            slots_d[pslot_d] = fin_cs;
          end
        end
        PH_DES2: begin
          if (b inside {[8'h29:8'h2b]}) begin
            pslot_d = b[1:0];
            ph_d    = PH_DES2F;
          end else if (ascsd_pkg::is_wide(fin_cs)) begin
            slots_d[0] = fin_cs;
          end
        end
        PH_DES2F: begin
          if (ascsd_pkg::is_wide(fin_cs)) begin
            slots_d[pslot_d] = fin_cs;
          end
        end
        PH_GL2: begin
          emit             = 1'b1;
          res.code_set     = cs_gl;
          res.first_code   = pfirst_d[6:0];
          res.second_code  = c;
          res.two_byte     = 1'b1;
          res.glyph_status = (cs_gl == ascsd_pkg::CS_KANJI || cs_gl == ascsd_pkg::CS_JIS1)
                             ? ascsd_pkg::GS_MAPPED : ascsd_pkg::GS_SQUARE;
        end
        PH_GR2: begin
          if (!b[7]) begin
            halt_d = 1'b1;
          end else begin
            emit             = 1'b1;
            res.code_set     = cs_gr;
            res.first_code   = pfirst_d[6:0];
            res.second_code  = c;
            res.two_byte     = 1'b1;
            res.glyph_status = (cs_gr == ascsd_pkg::CS_KANJI ||
                                cs_gr == ascsd_pkg::CS_JIS1)
                               ? ascsd_pkg::GS_MAPPED : ascsd_pkg::GS_SQUARE;
          end
        end
        default: begin
          ph_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q[0] <= ascsd_pkg::CS_KANJI;
      slots_q[1] <= ascsd_pkg::CS_ALNUM;
      slots_q[2] <= ascsd_pkg::CS_HIRA;
      slots_q[3] <= ascsd_pkg::CS_KATA;
      gl_q       <= 2'd0;
      gr_q       <= 2'd2;
      ph_q       <= PH_IDLE;
      pslot_q    <= 2'd0;
      pfirst_q   <= 8'd0;
      halt_q     <= 1'b0;
    end else if (pop_o) begin
      slots_q    <= slots_d;
      gl_q       <= gl_d;
      gr_q       <= gr_d;
      ph_q       <= ph_d;
      pslot_q    <= pslot_d;
      pfirst_q   <= pfirst_d;
      halt_q     <= halt_d;
    end
  end

  assign res_valid_o = pop_o && emit;
  assign res_o       = res;

endmodule

/* src/ascsd_out_stage.sv */
// ----------------------------------------------------------------------------
// ascsd_out_stage
// Result register: holds one decoded character until the sink takes it.
// ----------------------------------------------------------------------------
module ascsd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  output logic              take_ready_o,
  input  logic              res_valid_i,
  input  ascsd_pkg::res_t   res_i,
  output logic              valid_o,
  input  logic              ready_i,
  output ascsd_pkg::res_t   data_o
);

  logic            valid_q, valid_d;
  ascsd_pkg::res_t data_q;

  assign take_ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (take_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* src/arib_string_code_set_decoder_unit.sv */
// A byte goes from the input register through the decode stage into the result register.
// Throughput: one byte per cycle; the decode stage advances whenever the result register
// is empty or being drained, so the sink's ready sets the pace.
// Bytes that make no character (controls, escape sequences, first halves) give no result.
// Reset: asynchronous, active low; empties both registers and restores the initial
// designations, invocations, parser phase and halt flag.
// ----------------------------------------------------------------------------
// arib_string_code_set_decoder_unit
// Byte-serial 8-bit broadcast text decoder: tracks designations and shifts and
// emits each character as its code set, 7-bit codes and glyph status.
// ----------------------------------------------------------------------------
module arib_string_code_set_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ascsd_in_if.sink    in_i,
  ascsd_out_if.source out_o
);

  ascsd_pkg::in_t  in_data, item;
  ascsd_pkg::res_t res, out_data;
  logic            item_valid, pop, take_ready, res_valid;

  assign in_data.in_byte         = in_i.in_byte;
  assign in_data.start_of_string = in_i.start_of_string;

  ascsd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (in_data),
    .valid_o (item_valid),
    .pop_i   (pop),
    .data_o  (item)
  );

  ascsd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_ready_i (take_ready),
    .pop_o        (pop),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ascsd_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_ready_o (take_ready),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .valid_o      (out_o.valid),
    .ready_i      (out_o.ready),
    .data_o       (out_data)
  );

  assign out_o.code_set     = out_data.code_set;
  assign out_o.first_code   = out_data.first_code;
  assign out_o.second_code  = out_data.second_code;
  assign out_o.two_byte     = out_data.two_byte;
  assign out_o.glyph_status = out_data.glyph_status;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the broadcast text decoder. A directed byte string
// and then about a thousand random bytes built mostly from well-formed escape,
// shift and character sequences are sent through the byte channel. The
// byte channel has random idle gaps, the character channel random ready
// gaps and one long output hold-off. A model of the designation and shift
// state predicts every decoded character, and they are checked in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 1000;
  localparam int CALM_TAIL    = 150;
  localparam int HOLD_CYCLES  = 300;

  // Designator bytes that follow ESC or ESC 0x24.
  localparam logic [7:0] DES_G0 = 8'h28;
  localparam logic [7:0] DES_G1 = 8'h29;
  localparam logic [7:0] DES_G2 = 8'h2a;
  localparam logic [7:0] DES_G3 = 8'h2b;

  // Final bytes of designation sequences.
  localparam logic [7:0] F_HIRA    = 8'h30;
  localparam logic [7:0] F_KATA    = 8'h31;
  localparam logic [7:0] F_MOSA    = 8'h32;
  localparam logic [7:0] F_MOSB    = 8'h33;
  localparam logic [7:0] F_MOSC    = 8'h34;
  localparam logic [7:0] F_MOSD    = 8'h35;
  localparam logic [7:0] F_PALNUM  = 8'h36;
  localparam logic [7:0] F_PHIRA   = 8'h37;
  localparam logic [7:0] F_PKATA   = 8'h38;
  localparam logic [7:0] F_JIS1    = 8'h39;
  localparam logic [7:0] F_JIS2    = 8'h3a;
  localparam logic [7:0] F_SYMBOLS = 8'h3b;
  localparam logic [7:0] F_KANJI   = 8'h42;
  localparam logic [7:0] F_X0201K  = 8'h49;
  localparam logic [7:0] F_ALNUM   = 8'h4a;

  // Character byte ranges of the left and right halves.
  localparam logic [7:0] GL_LO = 8'h20;
  localparam logic [7:0] GL_HI = 8'h7f;
  localparam logic [7:0] GR_LO = 8'ha0;
  localparam logic [7:0] GR_HI = 8'hff;

  typedef enum logic [2:0] {
    DEC_IDLE, DEC_ESC, DEC_DESIG1, DEC_DESIG2, DEC_DESIG2_FINAL, DEC_GL_SECOND, DEC_GR_SECOND
  } dec_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  ascsd_in_if  byte_if ();
  ascsd_out_if char_if ();

  arib_string_code_set_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (char_if)
  );

  // Decoder state as the bench sees it.
  logic [3:0] slot_set [4];
  logic [1:0] gl_slot;
  logic [1:0] gr_slot;
  dec_phase_e dec_phase;
  logic [1:0] desig_slot;
  logic [7:0] lead_byte;
  logic       halted;

  ascsd_pkg::in_t  pending_bytes [$];
  ascsd_pkg::res_t expected_chars [$];
  ascsd_pkg::in_t  next_byte;
  ascsd_pkg::res_t seen_char;
  ascsd_pkg::res_t want_char;

  int   bytes_sent = 0;
  int   mismatches = 0;
  int   quiet_cycles = 0;
  int   src_gap;
  int   sink_gap;
  logic src_busy;
  logic hold_rx = 1'b0;

  function automatic logic idling_allowed();
    return pending_bytes.size() > CALM_TAIL;
  endfunction

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [3:0] charset_for_final(input logic [7:0] f);
    case (f)
      F_KANJI:   return ascsd_pkg::CS_KANJI;
      F_ALNUM:   return ascsd_pkg::CS_ALNUM;
      F_HIRA:    return ascsd_pkg::CS_HIRA;
      F_KATA:    return ascsd_pkg::CS_KATA;
      F_MOSA:    return ascsd_pkg::CS_MOSA;
      F_MOSB:    return ascsd_pkg::CS_MOSB;
      F_MOSC:    return ascsd_pkg::CS_MOSC;
      F_MOSD:    return ascsd_pkg::CS_MOSD;
      F_PALNUM:  return ascsd_pkg::CS_PALNUM;
      F_PHIRA:   return ascsd_pkg::CS_PHIRA;
      F_PKATA:   return ascsd_pkg::CS_PKATA;
      F_X0201K:  return ascsd_pkg::CS_X0201K;
      F_JIS1:    return ascsd_pkg::CS_JIS1;
      F_JIS2:    return ascsd_pkg::CS_JIS2;
      F_SYMBOLS: return ascsd_pkg::CS_SYMBOLS;
      default:   return ascsd_pkg::CS_UNKNOWN;
    endcase
  endfunction

  function automatic logic is_double_byte_set(input logic [3:0] cs);
    return cs == ascsd_pkg::CS_KANJI || cs == ascsd_pkg::CS_JIS1 ||
           cs == ascsd_pkg::CS_JIS2 || cs == ascsd_pkg::CS_SYMBOLS;
  endfunction

  task automatic clear_decoder_state();
    slot_set[0] = ascsd_pkg::CS_KANJI;
    slot_set[1] = ascsd_pkg::CS_ALNUM;
    slot_set[2] = ascsd_pkg::CS_HIRA;
    slot_set[3] = ascsd_pkg::CS_KATA;
    gl_slot     = 2'd0;
    gr_slot     = 2'd2;
    dec_phase   = DEC_IDLE;
    desig_slot  = 2'd0;
    lead_byte   = 8'h00;
    halted      = 1'b0;
  endtask

  // A set of the wrong width leaves the slot as it was.
  task automatic designate_slot(input logic [1:0] slot, input logic [7:0] f, input logic wide);
    logic [3:0] cs;
    cs = charset_for_final(f);
    if (is_double_byte_set(cs) == wide) slot_set[slot] = cs;
  endtask

  task automatic expect_char(input logic [3:0] cs, input logic [6:0] c1, input logic [6:0] c2,
                             input logic wide);
    ascsd_pkg::res_t ch;
    ch.code_set    = cs;
    ch.first_code  = c1;
    ch.second_code = wide ? c2 : 7'd0;
    ch.two_byte    = wide;
    if (wide) begin
      ch.glyph_status = (cs == ascsd_pkg::CS_KANJI || cs == ascsd_pkg::CS_JIS1) ?
                        ascsd_pkg::GS_MAPPED : ascsd_pkg::GS_SQUARE;
    end else begin
      ch.glyph_status = (c1 >= 7'h21 && c1 <= 7'h7e &&
                         (cs == ascsd_pkg::CS_ALNUM || cs == ascsd_pkg::CS_HIRA ||
                          cs == ascsd_pkg::CS_KATA)) ?
                        ascsd_pkg::GS_MAPPED : ascsd_pkg::GS_DOLLAR;
    end
    expected_chars.push_back(ch);
  endtask

  // Advances the decoder state by one byte and queues the character it makes.
  task automatic decode_byte(input logic [7:0] b, input logic sos);
    logic [3:0] cs;
    dec_phase_e ph;
    if (sos) clear_decoder_state();
    if (halted) return;
    ph = dec_phase;
    dec_phase = DEC_IDLE;
    case (ph)
      DEC_IDLE: begin
        if (b == ascsd_pkg::B_ESC) begin
          dec_phase = DEC_ESC;
        end else if (b == ascsd_pkg::B_LS0) begin
          gl_slot = 2'd0;
        end else if (b == ascsd_pkg::B_LS1) begin
          gl_slot = 2'd1;
        end else if (b >= GL_LO && b <= GL_HI) begin
          cs = slot_set[gl_slot];
          if (is_double_byte_set(cs)) begin
            lead_byte = b;
            dec_phase = DEC_GL_SECOND;
          end else begin
            expect_char(cs, b[6:0], 7'd0, 1'b0);
          end
        end else if (b >= GR_LO) begin
          cs = slot_set[gr_slot];
          if (is_double_byte_set(cs)) begin
            lead_byte = b;
            dec_phase = DEC_GR_SECOND;
          end else begin
            expect_char(cs, b[6:0], 7'd0, 1'b0);
          end
        end
      end
      DEC_ESC: begin
        if (b >= DES_G0 && b <= DES_G3) begin
          desig_slot = b[1:0];
          dec_phase  = DEC_DESIG1;
        end else if (b == ascsd_pkg::B_WIDE) begin
          dec_phase = DEC_DESIG2;
        end else if (b == ascsd_pkg::B_LS2) begin
          gl_slot = 2'd2;
        end else if (b == ascsd_pkg::B_LS3) begin
          gl_slot = 2'd3;
        end else if (b == ascsd_pkg::B_LS1R) begin
          gr_slot = 2'd1;
        end else if (b == ascsd_pkg::B_LS2R) begin
          gr_slot = 2'd2;
        end else if (b == ascsd_pkg::B_LS3R) begin
          gr_slot = 2'd3;
        end
      end
      DEC_DESIG1: designate_slot(desig_slot, b, 1'b0);
      DEC_DESIG2: begin
        if (b >= DES_G1 && b <= DES_G3) begin
          desig_slot = b[1:0];
          dec_phase  = DEC_DESIG2_FINAL;
        end else begin
          designate_slot(2'd0, b, 1'b1);
        end
      end
      DEC_DESIG2_FINAL: designate_slot(desig_slot, b, 1'b1);
      DEC_GL_SECOND: expect_char(slot_set[gl_slot], lead_byte[6:0], b[6:0], 1'b1);
      DEC_GR_SECOND: begin
        if (b < 8'h80) begin
          halted = 1'b1;
        end else begin
          expect_char(slot_set[gr_slot], lead_byte[6:0], b[6:0], 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_byte(input logic [7:0] b, input logic sos);
    pending_bytes.push_back(ascsd_pkg::in_t'{in_byte: b, start_of_string: sos});
  endtask

  // Stimulus and end of run.
  initial begin
    logic [7:0] fb;
    clear_decoder_state();

    // GL kanji pair with the largest first byte and a zero second byte.
    add_byte(8'h7f, 1'b1);
    add_byte(8'h00, 1'b0);
    // Shift G1 into GL: alnum space gives the dollar sign.
    add_byte(ascsd_pkg::B_LS1, 1'b0);
    add_byte(8'h20, 1'b0);
    // GR hiragana at the top code, then a byte that makes nothing.
    add_byte(8'hff, 1'b0);
    add_byte(8'h80, 1'b0);
    // ESC after ESC is swallowed.
    add_byte(ascsd_pkg::B_ESC, 1'b0);
    add_byte(ascsd_pkg::B_ESC, 1'b0);
    // Unknown final into G1; GL still points at G1.
    add_byte(ascsd_pkg::B_ESC, 1'b0);
    add_byte(DES_G1, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h7e, 1'b0);
    // JIS plane 1 into G2, which GR already invokes.
    add_byte(ascsd_pkg::B_ESC, 1'b0);
    add_byte(ascsd_pkg::B_WIDE, 1'b0);
    add_byte(DES_G2, 1'b0);
    add_byte(F_JIS1, 1'b0);
    add_byte(8'ha1, 1'b0);
    add_byte(8'hfe, 1'b0);
    // A two-byte set in a one-byte sequence leaves G0 alone.
    add_byte(ascsd_pkg::B_ESC, 1'b0);
    add_byte(DES_G0, 1'b0);
    add_byte(F_KANJI, 1'b0);
    // Broken GR pair halts the decoder.
    add_byte(8'ha1, 1'b0);
    add_byte(8'h41, 1'b0);
    // A sequence cut by a new string, then a kanji pair.
    add_byte(ascsd_pkg::B_ESC, 1'b1);
    add_byte(ascsd_pkg::B_WIDE, 1'b0);
    add_byte(8'h41, 1'b1);
    add_byte(8'h42, 1'b0);

    while (pending_bytes.size() < RANDOM_BYTES + 27) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          if ($urandom_range(0, 1) == 0) begin
            add_byte(8'($urandom_range(GL_LO, GL_HI)), $urandom_range(0, 59) == 0);
            if ($urandom_range(0, 4) != 0)
              add_byte(8'($urandom_range(GL_LO, GL_HI)), $urandom_range(0, 59) == 0);
          end else begin
            add_byte(8'($urandom_range(GR_LO, GR_HI)), $urandom_range(0, 59) == 0);
            if ($urandom_range(0, 4) != 0)
              add_byte(8'($urandom_range(GR_LO, GR_HI)), $urandom_range(0, 59) == 0);
          end
        end
        9, 10: add_byte($urandom_range(0, 1) ? ascsd_pkg::B_LS0 : ascsd_pkg::B_LS1,
                        $urandom_range(0, 59) == 0);
        11, 12: begin
          add_byte(ascsd_pkg::B_ESC, $urandom_range(0, 59) == 0);
          case ($urandom_range(0, 4))
            0: add_byte(ascsd_pkg::B_LS2, 1'b0);
            1: add_byte(ascsd_pkg::B_LS3, 1'b0);
            2: add_byte(ascsd_pkg::B_LS1R, 1'b0);
            3: add_byte(ascsd_pkg::B_LS2R, 1'b0);
            default: add_byte(ascsd_pkg::B_LS3R, 1'b0);
          endcase
        end
        13, 14, 15, 16: begin
          case ($urandom_range(0, 5))
            0: fb = 8'($urandom_range(0, 255));
            1: fb = F_KANJI;
            2: fb = $urandom_range(0, 1) ? F_ALNUM : F_X0201K;
            default: fb = F_HIRA + 8'($urandom_range(0, F_SYMBOLS - F_HIRA));
          endcase
          add_byte(ascsd_pkg::B_ESC, $urandom_range(0, 59) == 0);
          if ($urandom_range(0, 1) == 0) begin
            add_byte(DES_G0 + 8'($urandom_range(0, 3)), $urandom_range(0, 59) == 0);
          end else begin
            add_byte(ascsd_pkg::B_WIDE, $urandom_range(0, 59) == 0);
            if ($urandom_range(0, 3) != 0)
              add_byte(DES_G1 + 8'($urandom_range(0, 2)), $urandom_range(0, 59) == 0);
          end
          add_byte(fb, $urandom_range(0, 59) == 0);
        end
        17: add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        18: add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h1f)) :
                     8'($urandom_range(8'h80, 8'h9f)), $urandom_range(0, 59) == 0);
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            add_byte(8'($urandom_range(GR_LO, GR_HI)), 1'b0);
            add_byte(8'($urandom_range(8'h00, 8'h7f)), 1'b0);
          end else begin
            add_byte(ascsd_pkg::B_ESC, 1'b0);
            add_byte(8'($urandom_range(0, 255)), 1'b0);
          end
        end
      endcase
    end

    while (pending_bytes.size() != 0 || byte_if.valid || expected_chars.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Byte driver; bytes are predicted as they are accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.valid           <= 1'b0;
      byte_if.in_byte         <= 8'h00;
      byte_if.start_of_string <= 1'b0;
      src_gap = 0;
    end else begin
      src_busy = byte_if.valid;
      if (byte_if.valid && byte_if.ready) begin
        decode_byte(byte_if.in_byte, byte_if.start_of_string);
        bytes_sent++;
        src_busy = 1'b0;
      end
      if (!src_busy) begin
        if (src_gap == 0 && idling_allowed() && $urandom_range(0, 15) == 0)
          src_gap = $urandom_range(1, 11);
        if (src_gap > 0 || pending_bytes.size() == 0) begin
          if (src_gap > 0) src_gap--;
          byte_if.valid <= 1'b0;
        end else begin
          next_byte = pending_bytes.pop_front();
          byte_if.valid           <= 1'b1;
          byte_if.in_byte         <= next_byte.in_byte;
          byte_if.start_of_string <= next_byte.start_of_string;
        end
      end
    end
  end

  // Character monitor and output back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_if.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (char_if.valid && char_if.ready) begin
        seen_char.code_set     = char_if.code_set;
        seen_char.first_code   = char_if.first_code;
        seen_char.second_code  = char_if.second_code;
        seen_char.two_byte     = char_if.two_byte;
        seen_char.glyph_status = char_if.glyph_status;
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected character: set %0d codes %h %h wide %b glyph %0d",
                     seen_char.code_set, seen_char.first_code, seen_char.second_code,
                     seen_char.two_byte, seen_char.glyph_status);
        end else begin
          want_char = expected_chars.pop_front();
          if (seen_char !== want_char) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"character mismatch: expected set %0d codes %h %h wide %b ",
                        "glyph %0d, got set %0d codes %h %h wide %b glyph %0d"},
                       want_char.code_set, want_char.first_code, want_char.second_code,
                       want_char.two_byte, want_char.glyph_status,
                       seen_char.code_set, seen_char.first_code, seen_char.second_code,
                       seen_char.two_byte, seen_char.glyph_status);
          end
        end
      end
      if (sink_gap == 0 && idling_allowed() && $urandom_range(0, 11) == 0)
        sink_gap = $urandom_range(1, 11);
      if (hold_rx) begin
        char_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        char_if.ready <= 1'b0;
      end else begin
        char_if.ready <= 1'b1;
      end
    end
  end

  // One long output hold-off while bytes keep coming, so the input stalls.
  initial begin
    wait (bytes_sent >= 300);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin
    if ((byte_if.valid === 1'b1 && byte_if.ready === 1'b1) ||
        (char_if.valid === 1'b1 && char_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
